// File: rtl/rtk_pkg.sv
// ----------------------------------------------------------------------------
// rtk_pkg: shared types and constants of the ranked record table
// Word layouts, table sizing and the rank order compare.
// ----------------------------------------------------------------------------
package rtk_pkg;

    localparam int ENTRIES    = 1024;
    localparam int MAX_REPORT = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int REQ_W      = 7;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [63:0]       name_key;
        logic [7:0]        age;
        logic signed [31:0] worth;
        logic [REQ_W-1:0]  report_count;
        logic [7:0]        age_low;
        logic [7:0]        age_high;
    } cmd_word_t;

    typedef struct packed {
        logic [63:0]        out_name_key;
        logic [7:0]         out_age;
        logic signed [31:0] out_worth;
        logic               none_found;
        logic               last;
    } result_word_t;

    typedef struct packed {
        logic [63:0]        name_key;
        logic [7:0]         age;
        logic signed [31:0] worth;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // True when record x ranks strictly before record y
    function automatic logic ranks_before(input rec_t x, input rec_t y);
        logic r;
        if (x.worth != y.worth)
            r = (x.worth > y.worth);
        else if (x.age != y.age)
            r = (x.age < y.age);
        else
            r = (x.name_key < y.name_key);
        return r;
    endfunction

endpackage

// File: rtl/rtk_ram.sv
// ----------------------------------------------------------------------------
// rtk_ram: simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtk_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 104
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ranked_table_range_top_k_query.sv
// A load walks from the bottom of the table up, reading (INS_RD) and then
// comparing (INS_CMP) each entry it moves down; a query scans from the top,
// reading (QRY_RD) and comparing (QRY_CMP) each entry, holding each match
// until the next match, or the scan end or the requested count, sets last.
// One item at a time: start is taken only while busy is low. Results cannot be stalled.
// Reset clears the fill count and control; RAM contents stay undefined.
// ----------------------------------------------------------------------------
// ranked_table_range_top_k_query: ranked record table with top-k age query
// Keeps records sorted by rank in one RAM and reports age-filtered matches.
// ----------------------------------------------------------------------------
module ranked_table_range_top_k_query (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rtk_pkg::cmd_word_t    cmd,
    output logic                  busy,
    output logic                  strobe,
    output rtk_pkg::result_word_t result
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_RD  = 3'd1;
    localparam logic [2:0] ST_INS_CMP = 3'd2;
    localparam logic [2:0] ST_INS_TOP = 3'd3;
    localparam logic [2:0] ST_QRY_RD  = 3'd4;
    localparam logic [2:0] ST_QRY_CMP = 3'd5;
    localparam logic [2:0] ST_QRY_END = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [rtk_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [rtk_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [rtk_pkg::REQ_W-1:0]   got_reg, got_next;
    logic [rtk_pkg::REQ_W-1:0]   want_reg, want_next;
    logic [7:0]                  lo_reg, lo_next;
    logic [7:0]                  hi_reg, hi_next;
    rtk_pkg::rec_t               new_reg, new_next;
    rtk_pkg::rec_t               pend_reg, pend_next;
    logic                        pend_v_reg, pend_v_next;
    logic                        strobe_reg, strobe_next;
    rtk_pkg::result_word_t       result_reg, result_next;

    logic                        we;
    logic [rtk_pkg::IDX_W-1:0]   waddr;
    rtk_pkg::rec_t               wdata;
    rtk_pkg::rec_t               rdata;
    logic [rtk_pkg::REQ_W-1:0]   want_clamp;
    logic                        match;
    logic                        at_end;
    logic [rtk_pkg::CNT_W-1:0]   fill_m1;

    // Record store; a load reads entry i then writes i+1, so no access overlaps
    rtk_ram #(
        .DEPTH (rtk_pkg::ENTRIES),
        .WIDTH (rtk_pkg::REC_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign strobe  = strobe_reg;
    assign result  = result_reg;
    assign fill_m1 = fill_reg - rtk_pkg::CNT_W'(1);
    assign at_end  = ({1'b0, idx_reg} == fill_m1);
    assign match   = (rdata.age >= lo_reg) && (rdata.age <= hi_reg);
    assign want_clamp = (cmd.report_count > rtk_pkg::REQ_W'(rtk_pkg::MAX_REPORT))
                      ? rtk_pkg::REQ_W'(rtk_pkg::MAX_REPORT) : cmd.report_count;

    // Sequencer for load shifting and query scanning
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        got_next    = got_reg;
        want_next   = want_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        new_next    = new_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = idx_reg + rtk_pkg::IDX_W'(1);
        wdata       = new_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.kind == rtk_pkg::KIND_LOAD)
                    begin
                        new_next = '{cmd.name_key, cmd.age, cmd.worth};
                        if (fill_reg == rtk_pkg::CNT_W'(rtk_pkg::ENTRIES))
                            state_next = ST_IDLE;
                        else if (fill_reg == '0)
                            state_next = ST_INS_TOP;
                        else
                        begin
                            idx_next   = fill_m1[rtk_pkg::IDX_W-1:0];
                            state_next = ST_INS_RD;
                        end
                    end
                    else
                    begin
                        want_next   = want_clamp;
                        lo_next     = cmd.age_low;
                        hi_next     = cmd.age_high;
                        got_next    = '0;
                        pend_v_next = 1'b0;
                        idx_next    = '0;
                        if (want_clamp == '0 || fill_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            result_next = '{64'd0, 8'd0, 32'sd0, 1'b1, 1'b1};
                        end
                        else
                            state_next = ST_QRY_RD;
                    end
                end
            end

            ST_INS_RD:
                state_next = ST_INS_CMP;

            // Shift the entry down, or drop the new record in below it
            ST_INS_CMP:
            begin
                we = 1'b1;
                if (rtk_pkg::ranks_before(new_reg, rdata))
                begin
                    wdata = rdata;
                    if (idx_reg == '0)
                        state_next = ST_INS_TOP;
                    else
                    begin
                        idx_next   = idx_reg - rtk_pkg::IDX_W'(1);
                        state_next = ST_INS_RD;
                    end
                end
                else
                begin
                    fill_next  = fill_reg + rtk_pkg::CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_INS_TOP:
            begin
                we         = 1'b1;
                waddr      = '0;
                fill_next  = fill_reg + rtk_pkg::CNT_W'(1);
                state_next = ST_IDLE;
            end

            ST_QRY_RD:
                state_next = ST_QRY_CMP;

            // Hold one match back so the final word can carry last
            ST_QRY_CMP:
            begin
                if (match && (got_reg + rtk_pkg::REQ_W'(1) == want_reg))
                begin
                    strobe_next = 1'b1;
                    if (pend_v_reg)
                    begin
                        // Flush the held word; the final match follows with last
                        result_next = '{pend_reg.name_key, pend_reg.age,
                                        pend_reg.worth, 1'b0, 1'b0};
                        pend_next   = rdata;
                        state_next  = ST_QRY_END;
                    end
                    else
                    begin
                        result_next = '{rdata.name_key, rdata.age, rdata.worth,
                                        1'b0, 1'b1};
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    if (match)
                    begin
                        if (pend_v_reg)
                        begin
                            strobe_next = 1'b1;
                            result_next = '{pend_reg.name_key, pend_reg.age,
                                            pend_reg.worth, 1'b0, 1'b0};
                        end
                        pend_next   = rdata;
                        pend_v_next = 1'b1;
                        got_next    = got_reg + rtk_pkg::REQ_W'(1);
                    end
                    if (at_end)
                    begin
                        if (match)
                            state_next = ST_QRY_END;
                        else
                        begin
                            strobe_next = 1'b1;
                            state_next  = ST_IDLE;
                            if (pend_v_reg)
                                result_next = '{pend_reg.name_key, pend_reg.age,
                                                pend_reg.worth, 1'b0, 1'b1};
                            else
                                result_next = '{64'd0, 8'd0, 32'sd0, 1'b1, 1'b1};
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + rtk_pkg::IDX_W'(1);
                        state_next = ST_QRY_RD;
                    end
                end
            end

            ST_QRY_END:
            begin
                strobe_next = 1'b1;
                result_next = '{pend_reg.name_key, pend_reg.age, pend_reg.worth,
                                1'b0, 1'b1};
                state_next  = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            strobe_reg <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            strobe_reg <= strobe_next;
            pend_v_reg <= pend_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        got_reg    <= got_next;
        want_reg   <= want_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        new_reg    <= new_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

endmodule

// File: rtl/rtk_checker.sv
// ----------------------------------------------------------------------------
// rtk_checker: port level checks of the ranked record table
// Watches the command and result words at the top level ports.
// ----------------------------------------------------------------------------
module rtk_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input rtk_pkg::cmd_word_t    cmd,
    input logic                  busy,
    input logic                  strobe,
    input rtk_pkg::result_word_t result
);

    // A none word always closes its query
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.none_found |-> result.last)
        else $error("none word without last");

    // A none word carries zero fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.none_found |->
            (result.out_name_key == 64'd0) && (result.out_age == 8'd0) &&
            (result.out_worth == 32'sd0))
        else $error("none word with nonzero fields");

    // An accepted query either answers at once or keeps the block busy
    a_query_resp: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.kind == rtk_pkg::KIND_QUERY) |=> busy || strobe)
        else $error("query dropped");

    // A word that is not last leaves the query still running
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("query ended without last");

endmodule

bind ranked_table_range_top_k_query rtk_checker u_rtk_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

// File: tb/sv/ranked_table_range_top_k_query_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ranked_table_range_top_k_query_tb: self-checking bench for the ranked table
// Loads records and runs age-range queries; a local rank-ordered model
// predicts every result word, which is checked in order as it is strobed.
// ----------------------------------------------------------------------------
module ranked_table_range_top_k_query_tb;

    localparam int WATCH_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    rtk_pkg::cmd_word_t    cmd;
    logic                  busy;
    logic                  strobe;
    rtk_pkg::result_word_t result;

    // Local copy of the table in rank order
    logic [63:0]           tbl_name[$];
    logic [7:0]            tbl_age[$];
    logic signed [31:0]    tbl_worth[$];
    rtk_pkg::result_word_t expected_words[$];
    int                    error_count;
    int                    idle_cycles;
    bit                    use_gaps;

    ranked_table_range_top_k_query dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always #5 clk = ~clk;

    // True when record a ranks strictly ahead of record b
    function automatic bit goes_ahead(logic [63:0] an, logic [7:0] aa, logic signed [31:0] aw,
                                      logic [63:0] bn, logic [7:0] ba, logic signed [31:0] bw);
        if (aw != bw)
            return aw > bw;
        if (aa != ba)
            return aa < ba;
        return an < bn;
    endfunction

    // Update the table copy or queue the words a query should report
    task automatic predict_word(input rtk_pkg::cmd_word_t c);
        int pos;
        int want;
        int got;
        rtk_pkg::result_word_t w;
        pos = 0;
        got = 0;
        if (c.kind == rtk_pkg::KIND_LOAD)
        begin
            if (tbl_name.size() < rtk_pkg::ENTRIES)
            begin
                while (pos < tbl_name.size() &&
                       !goes_ahead(c.name_key, c.age, c.worth,
                                   tbl_name[pos], tbl_age[pos], tbl_worth[pos]))
                    pos++;
                tbl_name.insert(pos, c.name_key);
                tbl_age.insert(pos, c.age);
                tbl_worth.insert(pos, c.worth);
            end
        end
        else
        begin
            want = (c.report_count > rtk_pkg::MAX_REPORT) ? rtk_pkg::MAX_REPORT
                                                          : c.report_count;
            for (int i = 0; i < tbl_name.size() && got < want; i++)
            begin
                if (tbl_age[i] >= c.age_low && tbl_age[i] <= c.age_high)
                begin
                    w = '0;
                    w.out_name_key = tbl_name[i];
                    w.out_age = tbl_age[i];
                    w.out_worth = tbl_worth[i];
                    expected_words.insert(expected_words.size(), w);
                    got++;
                end
            end
            if (got == 0)
            begin
                w = '0;
                w.none_found = 1'b1;
                w.last = 1'b1;
                expected_words.insert(expected_words.size(), w);
            end
            else
                expected_words[expected_words.size() - 1].last = 1'b1;
        end
    endtask

    // Send one word: optional gap, then hold start until accepted
    task automatic send_word(input rtk_pkg::cmd_word_t c);
        int gap;
        gap = use_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(c);
    endtask

    task automatic send_load(input logic [63:0] n, input logic [7:0] a,
                             input logic signed [31:0] w);
        rtk_pkg::cmd_word_t c;
        c = '0;
        c.kind = rtk_pkg::KIND_LOAD;
        c.name_key = n;
        c.age = a;
        c.worth = w;
        send_word(c);
    endtask

    task automatic send_query(input logic [6:0] k, input logic [7:0] lo, input logic [7:0] hi);
        rtk_pkg::cmd_word_t c;
        c = '0;
        c.kind = rtk_pkg::KIND_QUERY;
        c.report_count = k;
        c.age_low = lo;
        c.age_high = hi;
        send_word(c);
    endtask

    // Random garbage in all fields
    function automatic rtk_pkg::cmd_word_t noise_word();
        rtk_pkg::cmd_word_t c;
        c.kind = 1'($urandom_range(0, 1));
        c.name_key = {$urandom, $urandom};
        c.age = 8'($urandom);
        c.worth = $urandom;
        c.report_count = 7'($urandom);
        c.age_low = 8'($urandom);
        c.age_high = 8'($urandom);
        return c;
    endfunction

    // Extremes, empty table, zero and large counts, reversed range, ties
    task automatic test_directed();
        send_query(7'd5, 8'd0, 8'd255);
        send_load(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 32'sh7FFF_FFFF);
        send_load(64'h0, 8'd0, 32'sh8000_0000);
        send_load(64'h4142_4300_0000_0000, 8'd30, 32'sd100);
        send_load(64'h4142_0000_0000_0000, 8'd30, 32'sd100);
        send_load(64'h4142_0000_0000_0000, 8'd30, 32'sd100);
        send_load(64'h5A00_0000_0000_0000, 8'd20, 32'sd100);
        send_load(64'h1, 8'd40, -32'sd1);
        send_query(7'd127, 8'd0, 8'd255);
        send_query(7'd0, 8'd0, 8'd255);
        send_query(7'd64, 8'd0, 8'd255);
        send_query(7'd3, 8'd30, 8'd30);
        send_query(7'd1, 8'd255, 8'd255);
        send_query(7'd4, 8'd50, 8'd10);
        send_query(7'd2, 8'd41, 8'd254);
        send_query(7'd1, 8'd0, 8'd0);
    endtask

    // Mostly loads over a narrow age band, queries with random windows, some noise
    task automatic test_random(input int count);
        rtk_pkg::cmd_word_t c;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                use_gaps = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: c = noise_word();
                1, 2, 3, 4, 5:
                begin
                    c = noise_word();
                    c.kind = rtk_pkg::KIND_LOAD;
                    c.age = ($urandom_range(0, 3) == 0) ? c.age
                                                        : 8'($urandom_range(18, 40));
                    if ($urandom_range(0, 3) == 0)
                        c.worth = $urandom_range(0, 4);
                end
                default:
                begin
                    c = noise_word();
                    c.kind = rtk_pkg::KIND_QUERY;
                    c.report_count = ($urandom_range(0, 4) == 0) ? c.report_count
                                                                 : 7'($urandom_range(1, 12));
                    c.age_low = 8'($urandom_range(15, 35));
                    c.age_high = 8'(c.age_low + $urandom_range(0, 10));
                end
            endcase
            send_word(c);
        end
    endtask

    // Check each strobed word against the oldest expectation
    always @(posedge clk)
    begin
        rtk_pkg::result_word_t e;
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", result);
                error_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (result.out_name_key !== e.out_name_key)
                begin
                    $error("out_name_key exp %h got %h", e.out_name_key, result.out_name_key);
                    error_count++;
                end
                if (result.out_age !== e.out_age)
                begin
                    $error("out_age exp %0d got %0d", e.out_age, result.out_age);
                    error_count++;
                end
                if (result.out_worth !== e.out_worth)
                begin
                    $error("out_worth exp %0d got %0d", e.out_worth, result.out_worth);
                    error_count++;
                end
                if (result.none_found !== e.none_found)
                begin
                    $error("none_found exp %b got %b", e.none_found, result.none_found);
                    error_count++;
                end
                if (result.last !== e.last)
                begin
                    $error("last exp %b got %b", e.last, result.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted word in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("ranked_table_range_top_k_query_tb: errors");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        error_count = 0;
        idle_cycles = 0;
        use_gaps = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(204);
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4 * rtk_pkg::ENTRIES + 20) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("ranked_table_range_top_k_query_tb: clean");
        else
            $display("ranked_table_range_top_k_query_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/rtk_pkg.sv
rtl/rtk_ram.sv
rtl/ranked_table_range_top_k_query.sv
rtl/rtk_checker.sv
tb/sv/ranked_table_range_top_k_query_tb.sv
